/* sv/trdt_pkg.sv */
// trdt_pkg: widths, register indexes, store word type and reset values
// shared by the triangle raster/depth-test block. No dependencies.
`default_nettype none
package trdt_pkg;

  localparam int XY_W        = 16;
  localparam int Z_W         = 16;
  localparam int COL_W       = 32;
  localparam int RIDX_W      = 12;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 48;
  localparam int EDGE_W      = 36;
  localparam int MULB_W      = 18;
  localparam int PROD_W      = 54;
  localparam int DIV_STEPS   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic [Z_W-1:0]   DEPTH_FAR = 16'hFFFF;

  typedef struct packed {
    logic [Z_W-1:0]   depth;
    logic [COL_W-1:0] colour;
  } store_word_t;

endpackage
`default_nettype wire

/* sv/triangle_raster_depth_test_top.sv */
// triangle_raster_depth_test_top: edge-function rasteriser with depth store.
// Depends on trdt_pkg and trdt_store.
//
// Usage: one input word on s_* is either a triangle (s_tuser = 0) or a
// pixel read (s_tuser = 1); every input word gives exactly one output word
// on m_*. A draw returns zeros once all pixels are written; a read returns
// the stored colour and depth, or zeros for an index past the store. s_tready
// is high only while the sequencer is idle, so one word is worked on at a time.
// Steps per word: a read accepts the word, reads the store and finishes. A draw
// accepts the word and runs its setup, then, if its area is positive, evaluates the
// edges of each pixel of the clamped bounding box; a covered pixel also gets its
// depth interpolated, divided and tested, and the finish step follows. All of it
// uses one shared 36x18 multiplier and a restoring divider, one quotient bit a cycle.
// After reset the store is swept to far depth and zero colour, one entry a
// cycle, over all MAX_WIDTH*MAX_HEIGHT entries (4096 by default); s_tready stays low
// meanwhile, configuration writes are taken at any time.
// The result waits in an output register; a stalled receiver holds the
// finished word and the block waits before returning to idle.
// cfg_index 0 = width in use, 1 = height in use; write only while idle.
`default_nettype none
module triangle_raster_depth_test_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [trdt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [trdt_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // mode
  input  wire logic                                 s_tuser,
  // vert0_x, vert0_y, vert0_depth, vert1_x, vert1_y, vert1_depth,
  // vert2_x, vert2_y, vert2_depth, fill_colour, read_index, zero pad
  input  wire logic [trdt_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // pixel_colour, pixel_depth
  output logic [trdt_pkg::OUT_TDATA_W-1:0]          m_tdata
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_READ   = 4'd2;
  localparam logic [3:0] ST_SETUP  = 4'd3;
  localparam logic [3:0] ST_EDGE   = 4'd4;
  localparam logic [3:0] ST_COVER  = 4'd5;
  localparam logic [3:0] ST_DEPTH  = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_TEST   = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [15:0] clamp_px(input logic signed [16:0] v,
                                           input logic [15:0] lim);
    logic signed [16:0] lim_s;
    lim_s = $signed({1'b0, lim});
    if (v < 0) return 16'd0;
    else if (v > lim_s) return lim;
    else return v[15:0];
  endfunction

  logic [3:0]  state;
  logic [3:0]  cnt;
  logic [trdt_pkg::CFG_W-1:0] width_in_use, height_in_use;

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [15:0]        vz [3];
  logic [trdt_pkg::COL_W-1:0] colour;
  logic          in_range;
  logic [trdt_pkg::COL_W-1:0] res_colour;
  logic [trdt_pkg::Z_W-1:0]   res_depth;

  logic [XW-1:0] x0, x1, x;
  logic [YW-1:0] y0, y1, y;
  logic [AW-1:0] row_base, clr_addr, pix_addr;

  logic signed [trdt_pkg::PROD_W-1:0] prod, acc;
  logic signed [trdt_pkg::EDGE_W-1:0] area;
  logic signed [trdt_pkg::EDGE_W-1:0] e [3];
  logic [trdt_pkg::PROD_W-1:0] rem, dsh;
  logic [15:0] q;
  logic        take;

  logic signed [trdt_pkg::EDGE_W-1:0] mul_a;
  logic signed [trdt_pkg::MULB_W-1:0] mul_b;

  logic signed [16:0] dx [3];
  logic signed [16:0] dy [3];
  logic [2:0] tl;
  logic       covered;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [XW-1:0] bx0, bx1;
  logic [YW-1:0] by0, by1;
  logic signed [17:0] px_s, py_s;

  logic [31:0] s_ridx32;
  logic        accept, advance;

  logic                  st_wr_en, st_rd_en;
  logic [AW-1:0]         st_wr_addr, st_rd_addr;
  trdt_pkg::store_word_t st_wr_word, st_rd_word;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i] = 17'(vx[(i + 1) % 3]) - 17'(vx[i]);
      dy[i] = 17'(vy[(i + 1) % 3]) - 17'(vy[i]);
      tl[i] = (dy[i] < 0) || ((dy[i] == 0) && (dx[i] > 0));
    end
  end

  always_comb begin
    covered = 1'b1;
    for (int i = 0; i < 3; i++)
      covered = covered && ((e[i] > 0) || ((e[i] == 0) && tl[i]));
  end

  always_comb begin
    if (width_in_use == '0) w_eff = WW'(1);
    else if (32'(width_in_use) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_in_use);
    if (height_in_use == '0) h_eff = HW'(1);
    else if (32'(height_in_use) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_in_use);
  end

  // bounding box in whole pixels: floor of min, ceil of max
  always_comb begin
    bx0 = XW'(clamp_px(17'(min3(vx[0], vx[1], vx[2])) >>> 4, 16'(w_eff) - 16'd1));
    bx1 = XW'(clamp_px((17'(max3(vx[0], vx[1], vx[2])) + 17'sd15) >>> 4,
                       16'(w_eff) - 16'd1));
    by0 = YW'(clamp_px(17'(min3(vy[0], vy[1], vy[2])) >>> 4, 16'(h_eff) - 16'd1));
    by1 = YW'(clamp_px((17'(max3(vy[0], vy[1], vy[2])) + 17'sd15) >>> 4,
                       16'(h_eff) - 16'd1));
  end

  assign px_s     = $signed(18'({x, 4'b1000}));
  assign py_s     = $signed(18'({y, 4'b1000}));
  assign pix_addr = row_base + AW'(x);
  assign s_ridx32 = 32'(s_tdata[187:176]);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign take     = (rem >= dsh);
  assign advance  = ((state == ST_COVER) && !covered) || (state == ST_TEST);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SETUP: begin
        case (cnt)
          4'd0: begin mul_a = 36'(dx[0]); mul_b = 18'(dy[2]); end
          4'd1: begin mul_a = 36'(dy[0]); mul_b = 18'(dx[2]); end
          default: begin
            mul_a = $signed(36'(y0));
            mul_b = $signed(18'(w_eff));
          end
        endcase
      end
      ST_EDGE: begin
        case (cnt)
          4'd0: begin mul_a = 36'(px_s - 18'(vx[0])); mul_b = 18'(dy[0]); end
          4'd1: begin mul_a = 36'(py_s - 18'(vy[0])); mul_b = 18'(dx[0]); end
          4'd2: begin mul_a = 36'(px_s - 18'(vx[1])); mul_b = 18'(dy[1]); end
          4'd3: begin mul_a = 36'(py_s - 18'(vy[1])); mul_b = 18'(dx[1]); end
          4'd4: begin mul_a = 36'(px_s - 18'(vx[2])); mul_b = 18'(dy[2]); end
          4'd5: begin mul_a = 36'(py_s - 18'(vy[2])); mul_b = 18'(dx[2]); end
          default: ;
        endcase
      end
      ST_DEPTH: begin
        case (cnt)
          4'd0: begin mul_a = e[1]; mul_b = $signed(18'(vz[0])); end
          4'd1: begin mul_a = e[2]; mul_b = $signed(18'(vz[1])); end
          default: begin mul_a = e[0]; mul_b = $signed(18'(vz[2])); end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    st_rd_en   = (accept && s_tuser) || ((state == ST_DEPTH) && (cnt == 4'd3));
    st_rd_addr = (state == ST_IDLE) ? s_ridx32[AW-1:0] : pix_addr;
    if (state == ST_CLEAR) begin
      st_wr_en          = 1'b1;
      st_wr_addr        = clr_addr;
      st_wr_word.depth  = trdt_pkg::DEPTH_FAR;
      st_wr_word.colour = '0;
    end else begin
      st_wr_en          = (state == ST_TEST) && (q <= st_rd_word.depth);
      st_wr_addr        = pix_addr;
      st_wr_word.depth  = q;
      st_wr_word.colour = colour;
    end
  end

  trdt_store #(
    .DEPTH(STORE),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_word(st_wr_word),
    .rd_en  (st_rd_en),
    .rd_addr(st_rd_addr),
    .rd_word(st_rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      cnt           <= '0;
      clr_addr      <= '0;
      m_tvalid      <= 1'b0;
      width_in_use  <= trdt_pkg::CFG_RESET;
      height_in_use <= trdt_pkg::CFG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trdt_pkg::CFG_WIDTH:  width_in_use  <= cfg_data;
          trdt_pkg::CFG_HEIGHT: height_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            for (int k = 0; k < 3; k++) begin
              vx[k] <= s_tdata[48*k +: 16];
              vy[k] <= s_tdata[48*k+16 +: 16];
              vz[k] <= s_tdata[48*k+32 +: 16];
            end
            colour     <= s_tdata[175:144];
            in_range   <= (s_ridx32 < 32'(STORE));
            res_colour <= '0;
            res_depth  <= '0;
            cnt        <= '0;
            state      <= s_tuser ? ST_READ : ST_SETUP;
          end
        end
        ST_READ: begin
          res_colour <= in_range ? st_rd_word.colour : '0;
          res_depth  <= in_range ? st_rd_word.depth : '0;
          state      <= ST_FINISH;
        end
        ST_SETUP: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd0: begin x0 <= bx0; x1 <= bx1; y0 <= by0; y1 <= by1; end
            4'd1: acc  <= prod;
            4'd2: area <= 36'(acc - prod);
            default: begin
              row_base <= AW'(prod);
              x        <= x0;
              y        <= y0;
              cnt      <= '0;
              state    <= (area <= 0) ? ST_FINISH : ST_EDGE;
            end
          endcase
        end
        ST_EDGE: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd1, 4'd3, 4'd5: acc <= prod;
            4'd2: e[0] <= 36'(acc - prod);
            4'd4: e[1] <= 36'(acc - prod);
            4'd6: begin
              e[2]  <= 36'(acc - prod);
              state <= ST_COVER;
            end
            default: ;
          endcase
        end
        ST_COVER: begin
          cnt <= '0;
          if (covered) state <= ST_DEPTH;
        end
        ST_DEPTH: begin
          cnt <= cnt + 4'd1;
          case (cnt)
            4'd1: acc <= prod;
            4'd2: acc <= acc + prod;
            4'd3: begin
              rem   <= $unsigned(acc + prod);
              dsh   <= 54'($unsigned(area)) << (trdt_pkg::DIV_STEPS - 1);
              q     <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (take) rem <= rem - dsh;
          q   <= {q[14:0], take};
          dsh <= dsh >> 1;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(trdt_pkg::DIV_STEPS - 1)) state <= ST_TEST;
        end
        ST_TEST: ;
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res_depth, res_colour};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // step to the next pixel of the box
      if (advance) begin
        cnt <= '0;
        if (x == x1) begin
          x <= x0;
          if (y == y1) begin
            state <= ST_FINISH;
          end else begin
            y        <= y + YW'(1);
            row_base <= row_base + AW'(w_eff);
            state    <= ST_EDGE;
          end
        end else begin
          x     <= x + XW'(1);
          state <= ST_EDGE;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/trdt_store.sv */
// trdt_store: depth and colour store, one write port and one registered
// read port. Depends on trdt_pkg.
`default_nettype none
module trdt_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire trdt_pkg::store_word_t wr_word,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output trdt_pkg::store_word_t      rd_word
);

  logic [trdt_pkg::Z_W-1:0]   depth_mem  [DEPTH];
  logic [trdt_pkg::COL_W-1:0] colour_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      depth_mem[wr_addr]  <= wr_word.depth;
      colour_mem[wr_addr] <= wr_word.colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word.depth  <= depth_mem[rd_addr];
      rd_word.colour <= colour_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/trdt_checker.sv */
// trdt_checker: port-level checks for triangle_raster_depth_test_top, and
// the bind that attaches them. Depends on trdt_pkg.
`default_nettype none
module trdt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [trdt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // no output word straight after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // store sweep keeps the input closed after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during store sweep");

  // one word at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready straight after accepting a word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

bind triangle_raster_depth_test_top trdt_checker u_trdt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

/* tb/sv/triangle_raster_depth_test_top_tb.sv */
// Testbench for triangle_raster_depth_test_top: checks draws and pixel reads
// against a predictor of the depth and colour stores. Depends on trdt_pkg.
`default_nettype none
module triangle_raster_depth_test_top_tb;

  localparam int NPIX = 4096;

  typedef struct {
    bit                 mode;
    logic [2:0][15:0]   vx;
    logic [2:0][15:0]   vy;
    logic [2:0][15:0]   vz;
    logic [31:0]        colour;
    logic [11:0]        ridx;
  } prim_t;

  typedef struct {
    logic [31:0] colour;
    logic [15:0] depth;
  } pixel_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [trdt_pkg::CFG_IDX_W-1:0]       cfg_index = trdt_pkg::CFG_WIDTH;
  logic [trdt_pkg::CFG_W-1:0]           cfg_data = '0;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic                                 s_tuser = 1'b0;
  logic [trdt_pkg::IN_TDATA_W-1:0]      s_tdata = '0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [trdt_pkg::OUT_TDATA_W-1:0]     m_tdata;

  triangle_raster_depth_test_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [15:0] zbuf [NPIX];
  logic [31:0] cbuf [NPIX];
  logic [6:0]  width_reg = 7'd64;
  logic [6:0]  height_reg = 7'd64;

  prim_t  prim_q[$];
  pixel_t pixel_q[$];
  int     errors = 0;
  int     results = 0;

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint qx, longint qy);
    return (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
  endfunction

  function automatic bit top_left_edge(longint ax, longint ay, longint bx, longint by);
    return (by - ay < 0) || (by == ay && bx - ax > 0);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rasterise(input prim_t p);
    longint x[3], y[3], z[3];
    longint w, h, area, xa, xb, ya, yb, e0, e1, e2, num, q, idx, qx, qy;
    bit t01, t12, t20;
    w = clampl(longint'(width_reg), 1, 64);
    h = clampl(longint'(height_reg), 1, 64);
    for (int i = 0; i < 3; i++) begin
      x[i] = longint'($signed(p.vx[i]));
      y[i] = longint'($signed(p.vy[i]));
      z[i] = longint'(p.vz[i]);
    end
    area = edge_fn(x[0], y[0], x[1], y[1], x[2], y[2]);
    if (area <= 0) return;
    xa = clampl((x[0] < x[1] ? (x[0] < x[2] ? x[0] : x[2]) : (x[1] < x[2] ? x[1] : x[2]))
                >>> 4, 0, w - 1);
    xb = clampl(((x[0] > x[1] ? (x[0] > x[2] ? x[0] : x[2]) : (x[1] > x[2] ? x[1] : x[2]))
                + 15) >>> 4, 0, w - 1);
    ya = clampl((y[0] < y[1] ? (y[0] < y[2] ? y[0] : y[2]) : (y[1] < y[2] ? y[1] : y[2]))
                >>> 4, 0, h - 1);
    yb = clampl(((y[0] > y[1] ? (y[0] > y[2] ? y[0] : y[2]) : (y[1] > y[2] ? y[1] : y[2]))
                + 15) >>> 4, 0, h - 1);
    t01 = top_left_edge(x[0], y[0], x[1], y[1]);
    t12 = top_left_edge(x[1], y[1], x[2], y[2]);
    t20 = top_left_edge(x[2], y[2], x[0], y[0]);
    for (longint py = ya; py <= yb; py++) begin
      for (longint px = xa; px <= xb; px++) begin
        qx = px * 16 + 8;
        qy = py * 16 + 8;
        e0 = edge_fn(x[0], y[0], x[1], y[1], qx, qy);
        e1 = edge_fn(x[1], y[1], x[2], y[2], qx, qy);
        e2 = edge_fn(x[2], y[2], x[0], y[0], qx, qy);
        if (!((e0 > 0 || (e0 == 0 && t01)) && (e1 > 0 || (e1 == 0 && t12)) &&
              (e2 > 0 || (e2 == 0 && t20)))) continue;
        num = e1 * z[0] + e2 * z[1] + e0 * z[2];
        q = num / area;
        if (num % area != 0 && num < 0) q--;
        q = clampl(q, 0, 65535);
        idx = py * w + px;
        if (idx < 0 || idx >= NPIX) continue;
        if (q <= longint'(zbuf[idx])) begin
          zbuf[idx] = q[15:0];
          cbuf[idx] = p.colour;
        end
      end
    end
  endtask

  task automatic predict_word(input prim_t p);
    pixel_t r;
    r.colour = '0;
    r.depth = '0;
    if (p.mode) begin
      r.colour = cbuf[p.ridx];
      r.depth = zbuf[p.ridx];
    end else begin
      rasterise(p);
    end
    pixel_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  prim_t cur;
  bit    loaded = 0;
  int    src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_word(cur);
        loaded = 0;
        src_gap = pick_gap();
      end
      if (!loaded) begin
        if (src_gap > 0) src_gap--;
        else if (prim_q.size() > 0) begin
          cur = prim_q.pop_front();
          loaded = 1;
        end
      end
      s_tvalid <= loaded;
      s_tuser <= cur.mode;
      s_tdata <= {4'b0, cur.ridx, cur.colour, cur.vz[2], cur.vy[2], cur.vx[2],
                  cur.vz[1], cur.vy[1], cur.vx[1], cur.vz[0], cur.vy[0], cur.vx[0]};
    end
  end

  // one long receiver hold-off after a few words so the input stalls
  int  hold_cycles = 0;
  bit  held = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (!held && results >= 6) begin
      held <= 1'b1;
      hold_cycles <= 600;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor
  int  snk_gap = 0;
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results++;
        if (pixel_q.size() == 0) begin
          report("unexpected word", m_tdata[31:0], '0);
        end else begin
          want = pixel_q.pop_front();
          if (m_tdata[31:0] !== want.colour) report("pixel_colour", m_tdata[31:0], want.colour);
          if (m_tdata[47:32] !== want.depth)
            report("pixel_depth", {16'b0, m_tdata[47:32]}, {16'b0, want.depth});
        end
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        snk_gap = pick_gap();
      end
    end
  end

  function automatic prim_t mk_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                   int x2, int y2, int z2, logic [31:0] colour);
    prim_t p;
    p.mode = 0;
    p.vx[0] = 16'(x0); p.vy[0] = 16'(y0); p.vz[0] = 16'(z0);
    p.vx[1] = 16'(x1); p.vy[1] = 16'(y1); p.vz[1] = 16'(z1);
    p.vx[2] = 16'(x2); p.vy[2] = 16'(y2); p.vz[2] = 16'(z2);
    p.colour = colour;
    p.ridx = 12'($urandom());
    return p;
  endfunction

  function automatic prim_t mk_read(int idx);
    prim_t p;
    p.mode = 1;
    p.vx = 48'({$urandom(), $urandom()});
    p.vy = 48'({$urandom(), $urandom()});
    p.vz = 48'({$urandom(), $urandom()});
    p.colour = $urandom();
    p.ridx = 12'(idx);
    return p;
  endfunction

  // random triangle near the active screen, mostly small and mostly of positive area
  function automatic prim_t rand_tri(int w, int h);
    prim_t p;
    int cx, cy, rad;
    logic [15:0] t;
    rad = ($urandom_range(0, 4) == 0) ? 12 * 16 : 4 * 16;
    cx = $urandom_range(0, (w + 2) * 16) - 16;
    cy = $urandom_range(0, (h + 2) * 16) - 16;
    p = mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom());
    for (int i = 0; i < 3; i++) begin
      p.vx[i] = 16'(cx + $urandom_range(0, 2 * rad) - rad);
      p.vy[i] = 16'(cy + $urandom_range(0, 2 * rad) - rad);
      if ($urandom_range(0, 2) == 0) begin
        p.vx[i] = {p.vx[i][15:3], 3'b000};
        p.vy[i] = {p.vy[i][15:3], 3'b000};
      end
      p.vz[i] = 16'($urandom());
    end
    if ($urandom_range(0, 9) != 0 &&
        edge_fn(longint'($signed(p.vx[0])), longint'($signed(p.vy[0])),
                longint'($signed(p.vx[1])), longint'($signed(p.vy[1])),
                longint'($signed(p.vx[2])), longint'($signed(p.vy[2]))) < 0) begin
      t = p.vx[1]; p.vx[1] = p.vx[2]; p.vx[2] = t;
      t = p.vy[1]; p.vy[1] = p.vy[2]; p.vy[2] = t;
    end
    return p;
  endfunction

  task automatic drain();
    while (prim_q.size() > 0 || loaded || pixel_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [trdt_pkg::CFG_IDX_W-1:0] idx, input logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == trdt_pkg::CFG_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int noise);
    int w, h;
    prim_t p;
    w = int'(clampl(longint'(width_reg), 1, 64));
    h = int'(clampl(longint'(height_reg), 1, 64));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3)
        p = mk_read($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                              : $urandom_range(0, w * h - 1));
      else if (i < noise)
        p = mk_tri($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
      else
        p = rand_tri(w, h);
      prim_q.push_back(p);
    end
  endtask

  initial begin
    for (int i = 0; i < NPIX; i++) begin
      zbuf[i] = trdt_pkg::DEPTH_FAR;
      cbuf[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, full screen
    prim_q.push_back(mk_read(0));
    prim_q.push_back(mk_read(4095));
    prim_q.push_back(mk_tri(-32768, -32768, 40000, -32768, 32767, 40000,
                            32767, -32768, 40000, 32'hFFFF_FFFF));
    prim_q.push_back(mk_read(0));
    prim_q.push_back(mk_read(4095));
    prim_q.push_back(mk_tri(8, 8, 0, 8, 72, 0, 72, 8, 0, 32'h1111_1111));
    prim_q.push_back(mk_tri(72, 8, 100, 8, 72, 100, 72, 72, 100, 32'h2222_2222));
    prim_q.push_back(mk_tri(8, 8, 5, 72, 8, 5, 8, 72, 5, 32'h3333_3333));
    prim_q.push_back(mk_tri(0, 0, 1, 160, 160, 1, 320, 320, 1, 32'h4444_4444));
    prim_q.push_back(mk_tri(-400, -400, 0, -400, -100, 0, -100, -400, 0, 32'h5555_5555));
    prim_q.push_back(mk_tri(1100, 1100, 0, 1100, 1500, 0, 1500, 1100, 0, 32'h6666_6666));
    prim_q.push_back(mk_tri(100, 100, 65535, 100, 900, 0, 900, 100, 30000, 32'h7777_7777));
    prim_q.push_back(mk_tri(0, 0, 65535, 0, 1024, 65535, 1024, 0, 65535, 32'h8888_8888));
    prim_q.push_back(mk_tri(24, 24, 0, 24, 40, 0, 40, 24, 0, 32'h9999_9999));
    prim_q.push_back(mk_read(0));
    prim_q.push_back(mk_read(65));
    prim_q.push_back(mk_read(130));
    prim_q.push_back(mk_read(2080));
    prim_q.push_back(mk_read(4032));
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd1);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd1);
    prim_q.push_back(mk_tri(-16, -16, 7, -16, 64, 7, 64, -16, 7, 32'hA5A5_A5A5));
    prim_q.push_back(mk_read(0));
    prim_q.push_back(mk_read(1));
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd0);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd127);
    prim_q.push_back(mk_tri(-16, -16, 3, -16, 2000, 3, 64, -16, 3, 32'h0F0F_0F0F));
    prim_q.push_back(mk_read(0));
    prim_q.push_back(mk_read(40));
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd127);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd0);
    prim_q.push_back(mk_tri(-16, -16, 2, -16, 64, 2, 2000, -16, 2, 32'hF0F0_F0F0));
    prim_q.push_back(mk_read(63));
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd8);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd8);
    random_phase(20, 10);
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd64);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd64);
    random_phase(55, 0);
    drain();

    write_reg(trdt_pkg::CFG_WIDTH, 7'd37);
    write_reg(trdt_pkg::CFG_HEIGHT, 7'd23);
    random_phase(40, 0);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

/* triangle_raster_depth_test_top.f */
sv/trdt_pkg.sv
sv/trdt_store.sv
sv/triangle_raster_depth_test_top.sv
sv/trdt_checker.sv
tb/sv/triangle_raster_depth_test_top_tb.sv
